FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on the i_clk / i_rst_n domain.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define FCW_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define FCW_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: sv/fcw_pkg.sv
// ---------------------------------------------------------------------------
// fcw_pkg
// Types, codes and defaults shared by the cluster chain walker modules.
// ---------------------------------------------------------------------------
package fcw_pkg;

    // Default sizes
    localparam int TABLE_BYTES_DEF = 16384;
    localparam int MAX_CHAIN_DEF   = 64;

    // Table formats (code 3 behaves as FAT32)
    localparam logic [1:0] FT_FAT12 = 2'd0;
    localparam logic [1:0] FT_FAT16 = 2'd1;
    localparam logic [1:0] FT_FAT32 = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_FAT_TYPE   = 2'd0;
    localparam logic [1:0] CFG_SEC_PER_CL = 2'd1;
    localparam logic [1:0] CFG_FIRST_DATA = 2'd2;

    // Configuration reset values
    localparam logic [1:0]  FAT_TYPE_RST   = FT_FAT16;
    localparam logic [7:0]  SEC_PER_CL_RST = 8'd1;
    localparam logic [31:0] FIRST_DATA_RST = 32'd0;

    // Item modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_WALK = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_RSV = 2'd1;
    localparam logic [1:0] ST_CAP = 2'd2;
    localparam logic [1:0] ST_BAD = 2'd3;

    // Top codes of each format, 28 bits wide
    localparam logic [27:0] TOP12 = 28'h0000FFF;
    localparam logic [27:0] TOP16 = 28'h000FFFF;
    localparam logic [27:0] TOP28 = 28'hFFFFFFF;

    // Commands from controller to datapath
    typedef struct packed {
        logic tbl_wr;
        logic load_start;
        logic look;
        logic rd;
        logic next;
        logic emit_rsv;
        logic emit_elem;
    } t_fcw_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic rsv;
        logic in_range;
        logic rd_last;
        logic elem_last;
        logic out_free;
    } t_fcw_sts;

endpackage

FILE: sv/fcw_ctrl.sv
// ---------------------------------------------------------------------------
// fcw_ctrl
// Sequencer for load and walk items: issues table reads per chain element
// and hands results to the output register.
// ---------------------------------------------------------------------------
module fcw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_mode,
    output logic              o_in_stall,
    input  fcw_pkg::t_fcw_sts i_sts,
    output fcw_pkg::t_fcw_cmd o_cmd
);
    import fcw_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_LOOK   = 3'd2;
    localparam logic [2:0] S_CHK    = 3'd3;
    localparam logic [2:0] S_RD     = 3'd4;
    localparam logic [2:0] S_TAIL   = 3'd5;
    localparam logic [2:0] S_DECIDE = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Take items only while idle
    assign o_in_stall = (r_state != S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_mode == MODE_WALK) begin
                        o_cmd.load_start = 1'b1;
                        n_state          = S_START;
                    end else begin
                        o_cmd.tbl_wr = 1'b1;
                    end
                end
            end
            S_START: begin
                if (i_sts.rsv) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit_rsv = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.look = 1'b1;
                    n_state    = S_CHK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = S_CHK;
            end
            S_CHK: begin
                n_state = i_sts.in_range ? S_RD : S_DECIDE;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                if (i_sts.rd_last) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_elem = 1'b1;
                    if (i_sts.elem_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.next = 1'b1;
                        n_state    = S_LOOK;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: sv/fcw_datapath.sv
// ---------------------------------------------------------------------------
// fcw_datapath
// Table memory, configuration registers, entry fetch and decode, sector
// arithmetic and the result register.
// ---------------------------------------------------------------------------
module fcw_datapath #(
    parameter int TABLE_BYTES = fcw_pkg::TABLE_BYTES_DEF,
    parameter int MAX_CHAIN   = fcw_pkg::MAX_CHAIN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fcw_pkg::t_fcw_cmd i_cmd,
    output fcw_pkg::t_fcw_sts o_sts,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    input  logic [13:0]       i_table_address,
    input  logic [7:0]        i_table_byte,
    input  logic [27:0]       i_start_cluster,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [27:0]       o_cluster,
    output logic [31:0]       o_first_sector,
    output logic [1:0]        o_status,
    output logic              o_last
);
    import fcw_pkg::*;

    localparam int AW = $clog2(TABLE_BYTES);
    localparam int NW = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;

    // Configuration
    logic [1:0]  r_type;
    logic [7:0]  r_spc;
    logic [31:0] r_fds;

    // Walk state
    logic [27:0] r_cur;
    logic [NW-1:0] r_n;
    logic [31:0] r_off;
    logic        r_in_range;
    logic [1:0]  r_cnt;
    logic [31:0] r_prod;

    // Table and fetch
    logic [7:0]  r_mem [TABLE_BYTES];
    logic [7:0]  r_rdata;
    logic        r_pend;
    logic [1:0]  r_pend_idx;
    logic [7:0]  r_lane [4];

    // Result register
    logic        r_ovalid;
    logic [27:0] r_ocluster;
    logic [31:0] r_osector;
    logic [1:0]  r_ostatus;
    logic        r_olast;

    logic        w_is32;
    logic [1:0]  w_lastidx;
    logic [27:0] w_top;
    logic [27:0] w_bad;
    logic [27:0] w_eoc;
    logic [31:0] w_off;
    logic [31:0] w_end;
    logic        w_wr_ok;
    logic [AW-1:0] w_wr_addr;
    logic [AW-1:0] w_rd_addr;
    logic [27:0] w_cm2;
    logic [35:0] w_prod;
    logic [27:0] w_link;
    logic        w_cap;
    logic [1:0]  w_status;
    logic        w_last;
    logic        w_out_free;

    // Format constants
    assign w_is32    = r_type[1];
    assign w_lastidx = w_is32 ? 2'd3 : 2'd1;
    always_comb begin
        case (r_type)
            FT_FAT12: w_top = TOP12;
            FT_FAT16: w_top = TOP16;
            default:  w_top = TOP28;
        endcase
    end
    assign w_bad = w_top - 28'd8;
    assign w_eoc = w_top - 28'd7;

    // Byte offset of the current entry and its last byte
    always_comb begin
        case (r_type)
            FT_FAT12: w_off = {4'd0, r_cur} + {5'd0, r_cur[27:1]};
            FT_FAT16: w_off = {3'd0, r_cur, 1'b0};
            default:  w_off = {2'd0, r_cur, 2'b00};
        endcase
    end
    assign w_end = w_off + {30'd0, w_lastidx};

    // Sector offset of the current cluster
    assign w_cm2  = r_cur - 28'd2;
    assign w_prod = {8'd0, w_cm2} * {28'd0, r_spc};

    // Table addresses
    assign w_wr_ok   = ({18'd0, i_table_address} < 32'(TABLE_BYTES));
    assign w_wr_addr = AW'({18'd0, i_table_address});
    assign w_rd_addr = AW'(r_off + {30'd0, r_cnt});

    // Assemble the link from fetched bytes
    always_comb begin
        case (r_type)
            FT_FAT12: begin
                if (r_cur[0]) begin
                    w_link = {16'd0, r_lane[1], r_lane[0][7:4]};
                end else begin
                    w_link = {16'd0, r_lane[1][3:0], r_lane[0]};
                end
            end
            FT_FAT16: w_link = {12'd0, r_lane[1], r_lane[0]};
            default:  w_link = {r_lane[3][3:0], r_lane[2], r_lane[1], r_lane[0]};
        endcase
    end

    // Classify the element
    assign w_cap = (r_n == NW'(MAX_CHAIN - 1));
    always_comb begin
        w_last   = 1'b1;
        w_status = ST_OK;
        if (!r_in_range) begin
            w_status = ST_BAD;
        end else if (w_link >= w_eoc) begin
            w_status = ST_OK;
        end else if ((w_link < 28'd2) || (w_link == w_bad)) begin
            w_status = ST_BAD;
        end else if (w_cap) begin
            w_status = ST_CAP;
        end else begin
            w_last = 1'b0;
        end
    end

    assign w_out_free = !r_ovalid || !i_out_stall;

    // Status to the controller
    assign o_sts.rsv       = (r_cur < 28'd2) || (r_cur >= w_bad);
    assign o_sts.in_range  = r_in_range;
    assign o_sts.rd_last   = (r_cnt == w_lastidx);
    assign o_sts.elem_last = w_last;
    assign o_sts.out_free  = w_out_free;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type <= FAT_TYPE_RST;
            r_spc  <= SEC_PER_CL_RST;
            r_fds  <= FIRST_DATA_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FAT_TYPE:   r_type <= i_cfg_data[1:0];
                CFG_SEC_PER_CL: r_spc  <= i_cfg_data[7:0];
                CFG_FIRST_DATA: r_fds  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Table memory: store on load items, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.tbl_wr && w_wr_ok) begin
            r_mem[w_wr_addr] <= i_table_byte;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    // Track the read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_cmd.rd;
        end
    end

    // Capture fetched bytes into their lanes
    always_ff @(posedge i_clk) begin
        r_pend_idx <= r_cnt;
        if (r_pend) begin
            r_lane[r_pend_idx] <= r_rdata;
        end
    end

    // Walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_start) begin
            r_cur <= i_start_cluster;
            r_n   <= '0;
        end else if (i_cmd.next) begin
            r_cur <= w_link;
            r_n   <= r_n + NW'(1);
        end
        if (i_cmd.look) begin
            r_off      <= w_off;
            r_in_range <= (w_end < 32'(TABLE_BYTES));
            r_cnt      <= 2'd0;
            r_prod     <= w_prod[31:0];
        end else if (i_cmd.rd) begin
            r_cnt <= r_cnt + 2'd1;
        end
    end

    // Result valid: set on emit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit_rsv || i_cmd.emit_elem) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_rsv) begin
            r_ocluster <= r_cur;
            r_osector  <= 32'd0;
            r_ostatus  <= ST_RSV;
            r_olast    <= 1'b1;
        end else if (i_cmd.emit_elem) begin
            r_ocluster <= r_cur;
            r_osector  <= r_prod + r_fds;
            r_ostatus  <= w_status;
            r_olast    <= w_last;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_cluster      = r_ocluster;
    assign o_first_sector = r_osector;
    assign o_status       = r_ostatus;
    assign o_last         = r_olast;

endmodule

FILE: sv/fat_cluster_chain_walker_core.sv
// ---------------------------------------------------------------------------
// fat_cluster_chain_walker_core
// Follows FAT12, FAT16 and FAT32 cluster chains held in an on-chip table.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall): a load item (i_mode 0) writes
//   i_table_byte at i_table_address when inside the table. A walk item (i_mode 1)
//   follows the chain from i_start_cluster and yields 1 to MAX_CHAIN results.
//   Output channel (o_out_valid / i_out_stall): one result per chain element,
//   o_last high on the final one.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 format,
//   1 sectors per cluster, 2 first data sector; write only while idle.
// Sequencing:
//   The table has one byte-wide port, so an entry inside the table is read one
//   byte at a time (two bytes for FAT12/FAT16, four for FAT32) after its offset
//   is computed and range-checked, and then its result is registered. A reserved
//   start cluster gives a single result without a table read. One item is
//   worked at a time; the next item is taken as soon as the last result sits
//   in the output register.
// Reset clears the configuration to FAT16, one sector per cluster, data at
// sector 0, and empties the output register; table contents stay undefined.
// A stalled receiver holds the result register and pauses the walk.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fat_cluster_chain_walker_core #(
    parameter int TABLE_BYTES = fcw_pkg::TABLE_BYTES_DEF,
    parameter int MAX_CHAIN   = fcw_pkg::MAX_CHAIN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [13:0] i_table_address,
    input  logic [7:0]  i_table_byte,
    input  logic [27:0] i_start_cluster,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [27:0] o_cluster,
    output logic [31:0] o_first_sector,
    output logic [1:0]  o_status,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import fcw_pkg::*;

    t_fcw_cmd w_cmd;
    t_fcw_sts w_sts;

    // Registers accept writes on every cycle
    assign o_cfg_ready = 1'b1;

    fcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    fcw_datapath #(
        .TABLE_BYTES (TABLE_BYTES),
        .MAX_CHAIN   (MAX_CHAIN)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_table_address (i_table_address),
        .i_table_byte    (i_table_byte),
        .i_start_cluster (i_start_cluster),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_cluster       (o_cluster),
        .o_first_sector  (o_first_sector),
        .o_status        (o_status),
        .o_last          (o_last)
    );

    // Never overwrite a result that the receiver has not taken
    `FCW_ASSERT_RST(a_emit_free, (w_cmd.emit_rsv || w_cmd.emit_elem) |-> (!o_out_valid || !i_out_stall), "result overwritten under stall")
    // Read only entries that lie inside the table
    `FCW_ASSERT_RST(a_rd_in_range, w_cmd.rd |-> w_sts.in_range, "table read beyond range")
    // A reserved start cluster ends its walk
    `FCW_ASSERT_RST(a_rsv_last, (o_out_valid && (o_status == ST_RSV)) |-> o_last, "reserved result not last")
    // Reset leaves the block idle and empty
    `FCW_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (!o_out_valid && !o_in_stall), "block busy after reset")

endmodule
